### hw/rtl/tbo_pkg.sv
`default_nettype none

package tbo_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int NUM_AXES        = 13;

   typedef logic [3:0] axis_type;

   localparam axis_type AXIS_NORMAL = 4'd12;
   localparam axis_type AXIS_NONE   = 4'd13;

   typedef enum logic [2:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } reg_index_type;

endpackage

`default_nettype wire

### hw/rtl/tbo_req_if.sv
`default_nettype none

interface tbo_req_if import tbo_pkg::*; #(parameter int W = COORD_WIDTH_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] vert_a_x;
   logic signed [W-1:0] vert_a_y;
   logic signed [W-1:0] vert_a_z;
   logic signed [W-1:0] vert_b_x;
   logic signed [W-1:0] vert_b_y;
   logic signed [W-1:0] vert_b_z;
   logic signed [W-1:0] vert_c_x;
   logic signed [W-1:0] vert_c_y;
   logic signed [W-1:0] vert_c_z;

   modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                   vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
   modport sink   (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                   vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

interface tbo_rsp_if import tbo_pkg::*;;
   logic     valid;
   logic     ready;
   logic     hit;
   axis_type separating_axis;

   modport source (output valid, hit, separating_axis, input ready);
   modport sink   (input valid, hit, separating_axis, output ready);
endinterface

`default_nettype wire

### hw/rtl/triangle_box_overlap_test.sv
`default_nettype none

// Triangle against axis-aligned box overlap test. Load the box corners once
// through the APB port (byte address 4*i: min x, min y, min z, max x, max y,
// max z), then stream triangles on req_ch; every triangle gives exactly one
// item on rsp_ch with hit and the first separating axis found (0-8 box axis
// crossed with an edge, 9-11 box faces, 12 triangle normal, 13 when hit).
// Touching counts as a hit. Arithmetic is exact integer math on doubled,
// centered coordinates. The pipeline takes one triangle per cycle while rsp_ch is
// not stalled; it is six register stages deep: three stages for the edge-axis
// and face tests, two for the wide normal products, one output register.
// A stall on rsp_ch freezes the whole pipeline.
module triangle_box_overlap_test import tbo_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tbo_req_if.sink                        req_ch,
   tbo_rsp_if.source                      rsp_ch,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready
);
   localparam int W  = COORD_WIDTH;
   localparam int NW = 2*W + 7;

   logic signed [W-1:0] mn_ff [3], mx_ff [3];
   logic signed [W-1:0] vert [9];
   logic signed [W-1:0] rd_val;
   reg_index_type       idx;

   logic [4:0]          vld_ff;      // stages 1..5
   logic                out_vld_ff;
   logic                out_hit_ff;
   axis_type            out_axis_ff, axis_in;
   logic                adv;

   logic [11:0]         sep_front;
   logic [11:0]         sep4_ff, sep5_ff;
   logic                sep_norm;
   logic signed [NW-1:0] n [3];
   logic signed [W+1:0] v0 [3];
   logic signed [W:0]   e [3];

   // ---- configuration ----
   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            mn_ff[i] <= '0;
            mx_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite && pready) begin
         unique case (idx)
            REG_BOX_MIN_X: mn_ff[0] <= pwdata[W-1:0];
            REG_BOX_MIN_Y: mn_ff[1] <= pwdata[W-1:0];
            REG_BOX_MIN_Z: mn_ff[2] <= pwdata[W-1:0];
            REG_BOX_MAX_X: mx_ff[0] <= pwdata[W-1:0];
            REG_BOX_MAX_Y: mx_ff[1] <= pwdata[W-1:0];
            REG_BOX_MAX_Z: mx_ff[2] <= pwdata[W-1:0];
            default: ;   // unmapped addresses ignored
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BOX_MIN_X: rd_val = mn_ff[0];
         REG_BOX_MIN_Y: rd_val = mn_ff[1];
         REG_BOX_MIN_Z: rd_val = mn_ff[2];
         REG_BOX_MAX_X: rd_val = mx_ff[0];
         REG_BOX_MAX_Y: rd_val = mx_ff[1];
         REG_BOX_MAX_Z: rd_val = mx_ff[2];
         default:       rd_val = '0;
      endcase
   end
   assign prdata = CSR_DATA_WIDTH'(rd_val);

   // ---- flow control: whole pipe moves unless the output item is stuck ----
   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[3:0], req_ch.valid};
         out_vld_ff <= vld_ff[4];
      end
   end

   assign vert[0] = req_ch.vert_a_x;
   assign vert[1] = req_ch.vert_a_y;
   assign vert[2] = req_ch.vert_a_z;
   assign vert[3] = req_ch.vert_b_x;
   assign vert[4] = req_ch.vert_b_y;
   assign vert[5] = req_ch.vert_b_z;
   assign vert[6] = req_ch.vert_c_x;
   assign vert[7] = req_ch.vert_c_y;
   assign vert[8] = req_ch.vert_c_z;

   tbo_front #(.W(W)) u_front (
      .clock (clock),
      .en    (adv),
      .vert  (vert),
      .mn    (mn_ff),
      .mx    (mx_ff),
      .sep   (sep_front),
      .n     (n),
      .v0    (v0),
      .e     (e)
   );

   tbo_normal #(.W(W)) u_normal (
      .clock (clock),
      .en    (adv),
      .n     (n),
      .v0    (v0),
      .e     (e),
      .sep   (sep_norm)
   );

   // align edge/face results with the normal test
   always_ff @(posedge clock) begin
      if (adv) begin
         sep4_ff <= sep_front;
         sep5_ff <= sep4_ff;
      end
   end

   // first separating axis wins
   always_comb begin
      axis_in = AXIS_NONE;
      if (sep_norm) axis_in = AXIS_NORMAL;
      for (int i = 11; i >= 0; i--) begin
         if (sep5_ff[i]) axis_in = axis_type'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_axis_ff <= axis_in;
         out_hit_ff  <= (axis_in == AXIS_NONE);
      end
   end

   assign rsp_ch.valid           = out_vld_ff;
   assign rsp_ch.hit             = out_hit_ff;
   assign rsp_ch.separating_axis = out_axis_ff;

   // ---- checks ----
   a_hit_axis: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_hit_ff == (out_axis_ff == AXIS_NONE)))
      else $error("hit flag disagrees with axis");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_axis_ff <= AXIS_NONE))
      else $error("axis code out of range");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while output stalled");

   a_pipe_shift: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[4]) |=> out_vld_ff)
      else $error("item lost at output stage");

endmodule

`default_nettype wire

### hw/rtl/tbo_front.sv
`default_nettype none

// Stages 1-3: centering, edge-cross axis projections, box faces, normal terms.
module tbo_front import tbo_pkg::*; #(
   parameter int W = COORD_WIDTH_DEF,
   localparam int NW = 2*W + 7
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [W-1:0] vert [9],
   input  wire logic signed [W-1:0] mn [3],
   input  wire logic signed [W-1:0] mx [3],
   output      logic [11:0]         sep,
   output      logic signed [NW-1:0] n [3],
   output      logic signed [W+1:0] v0 [3],
   output      logic signed [W:0]   e [3]
);
   localparam int VW = W + 2;
   localparam int FW = W + 3;
   localparam int PW = 2*W + 8;

   // stage 1
   logic signed [VW-1:0] v_ff [3][3];
   logic signed [FW-1:0] f_ff [3][3];
   logic signed [W:0]    e1_ff [3];
   // stage 2
   logic signed [PW-1:0] p_ff [9][3], p_in [9][3];
   logic signed [PW-1:0] r_ff [9], r_in [9];
   logic [2:0]           face_ff, face_in;
   logic signed [NW-1:0] np_ff [3][2], np_in [3][2];
   logic signed [VW-1:0] v2_ff [3];
   logic signed [W:0]    e2_ff [3];
   // stage 3
   logic [8:0]           edge_ff, edge_in;
   logic [2:0]           face3_ff;
   logic signed [NW-1:0] n_ff [3];
   logic signed [VW-1:0] v3_ff [3];
   logic signed [W:0]    e3_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               v_ff[k][i] <= (VW'(vert[3*k+i]) <<< 1) - (VW'(mn[i]) + VW'(mx[i]));
               f_ff[k][i] <= (FW'(vert[3*((k+1)%3)+i]) - FW'(vert[3*k+i])) <<< 1;
            end
         end
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= (W+1)'(mx[i]) - (W+1)'(mn[i]);
         end
      end
   end

   always_comb begin
      logic signed [FW:0]   fa1, fa2;
      logic signed [PW-1:0] lo, hi, rad;
      for (int b = 0; b < 3; b++) begin
         for (int j = 0; j < 3; j++) begin
            // axis = (0 at b, -f[j][b+2] at b+1, f[j][b+1] at b+2)
            for (int k = 0; k < 3; k++) begin
               p_in[3*b+j][k] = PW'(v_ff[k][(b+2)%3]) * PW'(f_ff[j][(b+1)%3])
                              - PW'(v_ff[k][(b+1)%3]) * PW'(f_ff[j][(b+2)%3]);
            end
            fa1 = (f_ff[j][(b+2)%3] < 0) ? -(FW+1)'(f_ff[j][(b+2)%3])
                                         : (FW+1)'(f_ff[j][(b+2)%3]);
            fa2 = (f_ff[j][(b+1)%3] < 0) ? -(FW+1)'(f_ff[j][(b+1)%3])
                                         : (FW+1)'(f_ff[j][(b+1)%3]);
            r_in[3*b+j] = PW'(e1_ff[(b+1)%3]) * PW'(fa1) + PW'(e1_ff[(b+2)%3]) * PW'(fa2);
         end
         // box face: interval of one coordinate against the half extent
         lo = PW'(v_ff[0][b]);
         hi = PW'(v_ff[0][b]);
         for (int k = 1; k < 3; k++) begin
            if (PW'(v_ff[k][b]) < lo) lo = PW'(v_ff[k][b]);
            if (PW'(v_ff[k][b]) > hi) hi = PW'(v_ff[k][b]);
         end
         rad = PW'(e1_ff[b]);
         face_in[b] = ((-hi > lo) ? -hi : lo) > rad;
         // normal cross product terms
         np_in[b][0] = NW'(f_ff[0][(b+1)%3]) * NW'(f_ff[1][(b+2)%3]);
         np_in[b][1] = NW'(f_ff[0][(b+2)%3]) * NW'(f_ff[1][(b+1)%3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         r_ff    <= r_in;
         face_ff <= face_in;
         np_ff   <= np_in;
         for (int i = 0; i < 3; i++) begin
            v2_ff[i] <= v_ff[0][i];
            e2_ff[i] <= e1_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [PW-1:0] lo, hi;
      for (int a = 0; a < 9; a++) begin
         lo = p_ff[a][0];
         hi = p_ff[a][0];
         for (int k = 1; k < 3; k++) begin
            if (p_ff[a][k] < lo) lo = p_ff[a][k];
            if (p_ff[a][k] > hi) hi = p_ff[a][k];
         end
         edge_in[a] = ((-hi > lo) ? -hi : lo) > r_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         edge_ff  <= edge_in;
         face3_ff <= face_ff;
         for (int i = 0; i < 3; i++) begin
            n_ff[i]  <= np_ff[i][0] - np_ff[i][1];
            v3_ff[i] <= v2_ff[i];
            e3_ff[i] <= e2_ff[i];
         end
      end
   end

   assign sep = {face3_ff, edge_ff};
   assign n   = n_ff;
   assign v0  = v3_ff;
   assign e   = e3_ff;

endmodule

`default_nettype wire

### hw/rtl/tbo_normal.sv
`default_nettype none

// Stages 4-5: triangle normal test, products split in two halves.
module tbo_normal import tbo_pkg::*; #(
   parameter int W = COORD_WIDTH_DEF,
   localparam int NW = 2*W + 7
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [NW-1:0] n [3],
   input  wire logic signed [W+1:0]  v0 [3],
   input  wire logic signed [W:0]    e [3],
   output      logic                 sep
);
   localparam int LO = W + 4;
   localparam int PPW = LO + W + 4;
   localparam int SW = 3*W + 12;

   logic signed [PPW-1:0] sl_ff [3], rl_ff [3];
   logic signed [PPW-1:0] sh_ff [3], rh_ff [3];
   logic                  sep_ff;

   always_ff @(posedge clock) begin
      logic [NW-1:0] mag;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag = (n[i] < 0) ? NW'(-n[i]) : NW'(n[i]);
            sl_ff[i] <= $signed(PPW'({1'b0, n[i][LO-1:0]})) * PPW'(v0[i]);
            sh_ff[i] <= PPW'($signed(n[i][NW-1:LO])) * PPW'(v0[i]);
            rl_ff[i] <= $signed(PPW'({1'b0, mag[LO-1:0]})) * PPW'(e[i]);
            rh_ff[i] <= $signed(PPW'({1'b0, mag[NW-1:LO]})) * PPW'(e[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [SW-1:0] s, r;
      if (en) begin
         s = '0;
         r = '0;
         for (int i = 0; i < 3; i++) begin
            s = s + (SW'(sh_ff[i]) <<< LO) + SW'(sl_ff[i]);
            r = r + (SW'(rh_ff[i]) <<< LO) + SW'(rl_ff[i]);
         end
         sep_ff <= ((s < 0) ? -s : s) > r;
      end
   end

   assign sep = sep_ff;

endmodule

`default_nettype wire
